[hdl/nlt_pkg.sv]
// Shared types, constants and the microprogram for the neighbor loss table.
// Used by the sequencer, the datapath and the top level.
`default_nettype none

package nlt_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  localparam logic FUNC_RECEIVE = 1'b0;
  localparam logic FUNC_REPORT  = 1'b1;

  typedef enum logic [3:0] {
    ST_WAIT     = 4'd0,
    ST_DISPATCH = 4'd1,
    ST_SCAN     = 4'd2,
    ST_CMP      = 4'd3,
    ST_UPDATE   = 4'd4,
    ST_FULLCHK  = 4'd5,
    ST_INSERT   = 4'd6,
    ST_REPORT   = 4'd7,
    ST_RD       = 4'd8,
    ST_EMIT     = 4'd9,
    ST_MORE     = 4'd10,
    ST_CLEAR    = 4'd11,
    ST_EMPTY    = 4'd12,
    ST_CLEAR_E  = 4'd13
  } step_t;

  typedef enum logic [3:0] {
    C_NEXT     = 4'd0,
    C_ALWAYS   = 4'd1,
    C_WAIT_IN  = 4'd2,
    C_REPORT   = 4'd3,
    C_END      = 4'd4,
    C_NOMATCH  = 4'd5,
    C_FULL     = 4'd6,
    C_EMPTY    = 4'd7,
    C_OUT_BUSY = 4'd8,
    C_MORE     = 4'd9
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  idx_clr;
    logic  rd_inc;
    logic  wr_upd;
    logic  wr_new;
    logic  emit_entry;
    logic  emit_empty;
    logic  cnt_clr;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic report;
    logic at_end;
    logic match;
    logic full;
    logic empty;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [15:0]       addr;
    logic [7:0]        last_id;
    logic [7:0]        total;
    logic [7:0]        lost;
    logic [7:0]        quality;
    logic signed [7:0] strength;
    logic [15:0]       metric;
    logic [31:0]       accum;
  } entry_t;

  typedef struct packed {
    logic              func;
    logic [15:0]       sender_addr;
    logic [7:0]        msg_id;
    logic [7:0]        link_quality;
    logic signed [7:0] signal_strength;
    logic [15:0]       route_metric;
    logic [31:0]       etx_sum;
  } in_beat_t;

  typedef struct packed {
    logic              entry_valid;
    logic [15:0]       from_addr;
    logic [15:0]       to_addr;
    logic [7:0]        total_count;
    logic [7:0]        lost_count;
    logic [7:0]        out_link_quality;
    logic signed [7:0] out_signal_strength;
    logic [15:0]       out_route_metric;
    logic [31:0]       out_etx_sum;
    logic [3:0]        entry_total;
    logic              last_of_report;
  } out_beat_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '0;
    c.cond = C_NEXT;
    c.target = ST_WAIT;
    case (s)
      ST_WAIT: begin
        c.in_ready = 1'b1;
        c.idx_clr = 1'b1;
        c.cond = C_WAIT_IN;
        c.target = ST_WAIT;
      end
      ST_DISPATCH: begin
        c.cond = C_REPORT;
        c.target = ST_REPORT;
      end
      ST_SCAN: begin
        c.rd_inc = 1'b1;
        c.cond = C_END;
        c.target = ST_FULLCHK;
      end
      ST_CMP: begin
        c.cond = C_NOMATCH;
        c.target = ST_SCAN;
      end
      ST_UPDATE: begin
        c.wr_upd = 1'b1;
        c.cond = C_ALWAYS;
        c.target = ST_WAIT;
      end
      ST_FULLCHK: begin
        c.cond = C_FULL;
        c.target = ST_WAIT;
      end
      ST_INSERT: begin
        c.wr_new = 1'b1;
        c.cond = C_ALWAYS;
        c.target = ST_WAIT;
      end
      ST_REPORT: begin
        c.cond = C_EMPTY;
        c.target = ST_EMPTY;
      end
      ST_RD: begin
        c.rd_inc = 1'b1;
      end
      ST_EMIT: begin
        c.emit_entry = 1'b1;
        c.cond = C_OUT_BUSY;
        c.target = ST_EMIT;
      end
      ST_MORE: begin
        c.cond = C_MORE;
        c.target = ST_RD;
      end
      ST_CLEAR: begin
        c.cnt_clr = 1'b1;
        c.cond = C_ALWAYS;
        c.target = ST_WAIT;
      end
      ST_EMPTY: begin
        c.emit_empty = 1'b1;
        c.cond = C_OUT_BUSY;
        c.target = ST_EMPTY;
      end
      ST_CLEAR_E: begin
        c.cnt_clr = 1'b1;
        c.cond = C_ALWAYS;
        c.target = ST_WAIT;
      end
      default: begin
        c.cond = C_ALWAYS;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/nlt_in_if.sv]
// Input channel of the neighbor loss table: valid, ready and one input beat.
// Depends on nothing.
`default_nettype none

interface nlt_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [15:0]       sender_addr;
  logic [7:0]        msg_id;
  logic [7:0]        link_quality;
  logic signed [7:0] signal_strength;
  logic [15:0]       route_metric;
  logic [31:0]       etx_sum;

  modport source (
    output valid, func, sender_addr, msg_id, link_quality, signal_strength,
           route_metric, etx_sum,
    input  ready
  );

  modport sink (
    input  valid, func, sender_addr, msg_id, link_quality, signal_strength,
           route_metric, etx_sum,
    output ready
  );
endinterface

`default_nettype wire

[hdl/nlt_out_if.sv]
// Result channel of the neighbor loss table: valid, ready and one result beat.
// Depends on nothing.
`default_nettype none

interface nlt_out_if;
  logic              valid;
  logic              ready;
  logic              entry_valid;
  logic [15:0]       from_addr;
  logic [15:0]       to_addr;
  logic [7:0]        total_count;
  logic [7:0]        lost_count;
  logic [7:0]        out_link_quality;
  logic signed [7:0] out_signal_strength;
  logic [15:0]       out_route_metric;
  logic [31:0]       out_etx_sum;
  logic [3:0]        entry_total;
  logic              last_of_report;

  modport source (
    output valid, entry_valid, from_addr, to_addr, total_count, lost_count,
           out_link_quality, out_signal_strength, out_route_metric, out_etx_sum,
           entry_total, last_of_report,
    input  ready
  );

  modport sink (
    input  valid, entry_valid, from_addr, to_addr, total_count, lost_count,
           out_link_quality, out_signal_strength, out_route_metric, out_etx_sum,
           entry_total, last_of_report,
    output ready
  );
endinterface

`default_nettype wire

[hdl/nlt_seq.sv]
// Microcode sequencer: step counter, program table and jump condition select.
// Depends on nlt_pkg for the control word, status and step types.
`default_nettype none

module nlt_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire nlt_pkg::stat_t stat,
  output nlt_pkg::ctrl_t      ctrl
);

  nlt_pkg::step_t upc_r;
  nlt_pkg::step_t upc_nxt;
  logic           taken;

  assign ctrl = nlt_pkg::ucode(upc_r);

  always_comb begin
    case (ctrl.cond)
      nlt_pkg::C_NEXT:     taken = 1'b0;
      nlt_pkg::C_ALWAYS:   taken = 1'b1;
      nlt_pkg::C_WAIT_IN:  taken = !stat.accept;
      nlt_pkg::C_REPORT:   taken = stat.report;
      nlt_pkg::C_END:      taken = stat.at_end;
      nlt_pkg::C_NOMATCH:  taken = !stat.match;
      nlt_pkg::C_FULL:     taken = stat.full;
      nlt_pkg::C_EMPTY:    taken = stat.empty;
      nlt_pkg::C_OUT_BUSY: taken = stat.out_busy;
      nlt_pkg::C_MORE:     taken = !stat.at_end;
      default:             taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      upc_nxt = ctrl.target;
    end else begin
      upc_nxt = nlt_pkg::step_t'(upc_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= nlt_pkg::ST_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  a_dispatch_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == nlt_pkg::ST_DISPATCH) |-> $past(stat.accept))
    else $error("dispatch step entered without an accepted beat");

  a_update_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == nlt_pkg::ST_UPDATE) |-> $past(stat.match))
    else $error("update step entered without an address match");

  a_insert_after_room: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == nlt_pkg::ST_INSERT) |-> $past(!stat.full))
    else $error("insert step entered with a full table");

endmodule

`default_nettype wire

[hdl/nlt_dp.sv]
// Datapath: neighbor table memory, scan index, entry count, input latch and
// result register, all driven by the control word. Depends on nlt_pkg and
// the two channel interfaces.
`default_nettype none

module nlt_dp #(
  parameter int TABLE_ENTRIES = nlt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_wdata,
  input  wire nlt_pkg::ctrl_t ctrl,
  output nlt_pkg::stat_t      stat,
  nlt_in_if.sink              in_ch,
  nlt_out_if.source           out_ch
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  nlt_pkg::entry_t   mem [TABLE_ENTRIES];
  nlt_pkg::entry_t   rdata_r;
  nlt_pkg::entry_t   wdata;
  nlt_pkg::in_beat_t in_r;
  nlt_pkg::out_beat_t out_r;
  nlt_pkg::out_beat_t out_nxt;
  logic [15:0]       own_addr_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     idx_nxt;
  logic [IW-1:0]     rd_idx_r;
  logic [IW-1:0]     wr_addr;
  logic              wr_en;
  logic              rd_en;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;
  logic              out_load;
  logic              accept;
  logic [CW+3:0]     count_ext;

  assign accept    = in_ch.valid && ctrl.in_ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign rd_en     = ctrl.rd_inc && (idx_r != count_r);
  assign wr_en     = ctrl.wr_upd || ctrl.wr_new;
  assign wr_addr   = ctrl.wr_new ? count_r[IW-1:0] : rd_idx_r;
  assign out_load  = (ctrl.emit_entry || ctrl.emit_empty) && out_free;
  assign count_ext = {4'd0, count_r};

  assign in_ch.ready = ctrl.in_ready;

  always_comb begin
    stat.accept   = accept;
    stat.report   = (in_r.func == nlt_pkg::FUNC_REPORT);
    stat.at_end   = (idx_r == count_r);
    stat.match    = (rdata_r.addr == in_r.sender_addr);
    stat.full     = (count_r == CW'(TABLE_ENTRIES));
    stat.empty    = (count_r == '0);
    stat.out_busy = !out_free;
  end

  always_comb begin
    wdata.last_id  = in_r.msg_id;
    wdata.quality  = in_r.link_quality;
    wdata.strength = in_r.signal_strength;
    wdata.metric   = in_r.route_metric;
    wdata.accum    = in_r.etx_sum;
    if (ctrl.wr_new) begin
      wdata.addr  = in_r.sender_addr;
      wdata.total = 8'd0;
      wdata.lost  = 8'd0;
    end else if (rdata_r.last_id < in_r.msg_id) begin
      wdata.addr  = rdata_r.addr;
      wdata.total = in_r.msg_id;
      wdata.lost  = rdata_r.lost + in_r.msg_id - rdata_r.last_id - 8'd1;
    end else begin
      wdata.addr  = rdata_r.addr;
      wdata.total = 8'd0;
      wdata.lost  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r  <= mem[idx_r[IW-1:0]];
      rd_idx_r <= idx_r[IW-1:0];
    end
    if (accept) begin
      in_r.func            <= in_ch.func;
      in_r.sender_addr     <= in_ch.sender_addr;
      in_r.msg_id          <= in_ch.msg_id;
      in_r.link_quality    <= in_ch.link_quality;
      in_r.signal_strength <= in_ch.signal_strength;
      in_r.route_metric    <= in_ch.route_metric;
      in_r.etx_sum         <= in_ch.etx_sum;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (ctrl.idx_clr) begin
      idx_nxt = '0;
    end else if (rd_en) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.cnt_clr) begin
      count_nxt = '0;
    end else if (ctrl.wr_new) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    out_nxt = '0;
    if (ctrl.emit_entry) begin
      out_nxt.entry_valid         = 1'b1;
      out_nxt.from_addr           = rdata_r.addr;
      out_nxt.to_addr             = own_addr_r;
      out_nxt.total_count         = rdata_r.total;
      out_nxt.lost_count          = rdata_r.lost;
      out_nxt.out_link_quality    = rdata_r.quality;
      out_nxt.out_signal_strength = rdata_r.strength;
      out_nxt.out_route_metric    = rdata_r.metric;
      out_nxt.out_etx_sum         = rdata_r.accum;
      out_nxt.entry_total         = count_ext[3:0];
      out_nxt.last_of_report      = (idx_r == count_r);
    end else begin
      out_nxt.last_of_report      = 1'b1;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r  <= 16'd0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        own_addr_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.entry_valid         = out_r.entry_valid;
  assign out_ch.from_addr           = out_r.from_addr;
  assign out_ch.to_addr             = out_r.to_addr;
  assign out_ch.total_count         = out_r.total_count;
  assign out_ch.lost_count          = out_r.lost_count;
  assign out_ch.out_link_quality    = out_r.out_link_quality;
  assign out_ch.out_signal_strength = out_r.out_signal_strength;
  assign out_ch.out_route_metric    = out_r.out_route_metric;
  assign out_ch.out_etx_sum         = out_r.out_etx_sum;
  assign out_ch.entry_total         = out_r.entry_total;
  assign out_ch.last_of_report      = out_r.last_of_report;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_new |-> (count_r < CW'(TABLE_ENTRIES)))
    else $error("insert into a full table");

  a_update_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_upd |-> (CW'(rd_idx_r) < count_r))
    else $error("update of an unused entry");

endmodule

`default_nettype wire

[hdl/neighbor_loss_table_top.sv]
// Top level of the neighbor loss table: sequencer plus datapath.
// Depends on nlt_pkg, nlt_in_if, nlt_out_if, nlt_seq and nlt_dp.
//
// Usage: in_ch carries one beat per received broadcast (func 0) or one
// report request (func 1). A receive beat updates the sender's entry, or
// creates it if the table has room, and yields nothing. A report beat
// yields one result beat per used entry in table order, the final one
// flagged by last_of_report, then empties the table; an empty table yields
// a single beat with entry_valid 0. cfg_we writes own_address from
// cfg_wdata, reported as to_addr.
// Timing: in_ch.ready is high only while the sequencer waits for a beat.
// A receive beat is checked against the used entries in table order, each
// read from memory and then compared; the next beat is taken only after
// the update, the insert or, on a full table, the drop. A report reads
// and emits each entry in turn, then clears the entry count.
// Reset clears the entry count, the result valid and own_address; the table
// memory itself is not cleared. When out_ch stalls, the pending result holds
// and the sequencer waits at an emit step until the result register frees.
`default_nettype none

module neighbor_loss_table_top #(
  parameter int TABLE_ENTRIES = nlt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  nlt_in_if.sink           in_ch,
  nlt_out_if.source        out_ch
);

  nlt_pkg::ctrl_t ctrl;
  nlt_pkg::stat_t stat;

  nlt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  nlt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[tb/neighbor_loss_table_top_tb.sv]
// Self-checking testbench for neighbor_loss_table_top: directed and random beats,
// with a predicted neighbor table checked against every result beat.
// Depends on nlt_pkg, nlt_in_if, nlt_out_if and the neighbor_loss_table_top RTL.
`default_nettype none

module neighbor_loss_table_top_tb;

  localparam int NBR_SLOTS  = nlt_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE  = 10;
  localparam int SETTLE_CYC = 40;
  localparam int CYCLE_CAP  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  nlt_in_if  in_ch();
  nlt_out_if out_ch();

  neighbor_loss_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted state of the block.
  nlt_pkg::entry_t    nbr_tbl [NBR_SLOTS];
  int                 nbr_used = 0;
  logic [15:0]        own_addr = 16'h0000;
  nlt_pkg::out_beat_t pending_reports [$];

  nlt_pkg::in_beat_t  beat_q [$];
  nlt_pkg::in_beat_t  drv_beat;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          cycles = 0;

  logic [15:0] addr_pool [POOL_SIZE];
  logic [7:0]  pool_id [POOL_SIZE];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = nlt_pkg::FUNC_RECEIVE;
    in_ch.sender_addr = '0;
    in_ch.msg_id = '0;
    in_ch.link_quality = '0;
    in_ch.signal_strength = '0;
    in_ch.route_metric = '0;
    in_ch.etx_sum = '0;
    out_ch.ready = 1'b0;
  end

  function automatic void predict_neighbors(nlt_pkg::in_beat_t b);
    bit                 hit;
    nlt_pkg::out_beat_t r;
    hit = 1'b0;
    if (b.func == nlt_pkg::FUNC_RECEIVE) begin
      for (int k = 0; k < nbr_used; k++) begin
        if (!hit && nbr_tbl[k].addr == b.sender_addr) begin
          hit = 1'b1;
          if (nbr_tbl[k].last_id < b.msg_id) begin
            nbr_tbl[k].lost = nbr_tbl[k].lost + b.msg_id - nbr_tbl[k].last_id - 8'd1;
            nbr_tbl[k].total = b.msg_id;
          end else begin
            nbr_tbl[k].total = 8'd0;
            nbr_tbl[k].lost = 8'd0;
          end
          nbr_tbl[k].last_id = b.msg_id;
          nbr_tbl[k].quality = b.link_quality;
          nbr_tbl[k].strength = b.signal_strength;
          nbr_tbl[k].metric = b.route_metric;
          nbr_tbl[k].accum = b.etx_sum;
        end
      end
      if (!hit && nbr_used < NBR_SLOTS) begin
        nbr_tbl[nbr_used].addr = b.sender_addr;
        nbr_tbl[nbr_used].total = 8'd0;
        nbr_tbl[nbr_used].lost = 8'd0;
        nbr_tbl[nbr_used].last_id = b.msg_id;
        nbr_tbl[nbr_used].quality = b.link_quality;
        nbr_tbl[nbr_used].strength = b.signal_strength;
        nbr_tbl[nbr_used].metric = b.route_metric;
        nbr_tbl[nbr_used].accum = b.etx_sum;
        nbr_used++;
      end
    end else begin
      if (nbr_used == 0) begin
        r = '0;
        r.last_of_report = 1'b1;
        pending_reports.push_back(r);
      end
      for (int k = 0; k < nbr_used; k++) begin
        r.entry_valid = 1'b1;
        r.from_addr = nbr_tbl[k].addr;
        r.to_addr = own_addr;
        r.total_count = nbr_tbl[k].total;
        r.lost_count = nbr_tbl[k].lost;
        r.out_link_quality = nbr_tbl[k].quality;
        r.out_signal_strength = nbr_tbl[k].strength;
        r.out_route_metric = nbr_tbl[k].metric;
        r.out_etx_sum = nbr_tbl[k].accum;
        r.entry_total = 4'(nbr_used);
        r.last_of_report = (k == nbr_used - 1);
        pending_reports.push_back(r);
      end
      nbr_used = 0;
    end
  endfunction

  function automatic nlt_pkg::in_beat_t gen_beat(int report_pct);
    nlt_pkg::in_beat_t b;
    int                p;
    b.func = nlt_pkg::FUNC_RECEIVE;
    b.sender_addr = 16'($urandom);
    b.msg_id = 8'($urandom);
    b.link_quality = 8'($urandom);
    b.signal_strength = 8'($urandom);
    b.route_metric = 16'($urandom);
    b.etx_sum = $urandom;
    if ($urandom_range(99) < report_pct) begin
      b.func = nlt_pkg::FUNC_REPORT;
    end else if ($urandom_range(99) < 90) begin
      p = $urandom_range(POOL_SIZE - 1);
      b.sender_addr = addr_pool[p];
      if ($urandom_range(99) < 85) begin
        b.msg_id = pool_id[p] + 8'($urandom_range(4, 1));
      end
      pool_id[p] = b.msg_id;
    end
    return b;
  endfunction

  task automatic refill_pool();
    for (int p = 0; p < POOL_SIZE; p++) begin
      addr_pool[p] = 16'($urandom);
      pool_id[p] = 8'($urandom);
    end
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
  endtask

  task automatic add_rx(logic [15:0] addr, logic [7:0] id, logic [7:0] lq,
                        logic [7:0] ss, logic [15:0] metric, logic [31:0] etx);
    nlt_pkg::in_beat_t b;
    b.func = nlt_pkg::FUNC_RECEIVE;
    b.sender_addr = addr;
    b.msg_id = id;
    b.link_quality = lq;
    b.signal_strength = ss;
    b.route_metric = metric;
    b.etx_sum = etx;
    beat_q.push_back(b);
  endtask

  task automatic add_report();
    nlt_pkg::in_beat_t b;
    b = '1;
    b.func = nlt_pkg::FUNC_REPORT;
    beat_q.push_back(b);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (beat_q.size() != 0 || in_ch.valid || pending_reports.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_own_address(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    own_addr = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result();
    nlt_pkg::out_beat_t got;
    nlt_pkg::out_beat_t want;
    got.entry_valid = out_ch.entry_valid;
    got.from_addr = out_ch.from_addr;
    got.to_addr = out_ch.to_addr;
    got.total_count = out_ch.total_count;
    got.lost_count = out_ch.lost_count;
    got.out_link_quality = out_ch.out_link_quality;
    got.out_signal_strength = out_ch.out_signal_strength;
    got.out_route_metric = out_ch.out_route_metric;
    got.out_etx_sum = out_ch.out_etx_sum;
    got.entry_total = out_ch.entry_total;
    got.last_of_report = out_ch.last_of_report;
    if (pending_reports.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
      errors++;
    end else begin
      want = pending_reports.pop_front();
      cmp_field("entry_valid", want.entry_valid, got.entry_valid);
      cmp_field("from_addr", want.from_addr, got.from_addr);
      cmp_field("to_addr", want.to_addr, got.to_addr);
      cmp_field("total_count", want.total_count, got.total_count);
      cmp_field("lost_count", want.lost_count, got.lost_count);
      cmp_field("out_link_quality", want.out_link_quality, got.out_link_quality);
      cmp_field("out_signal_strength", want.out_signal_strength, got.out_signal_strength);
      cmp_field("out_route_metric", want.out_route_metric, got.out_route_metric);
      cmp_field("out_etx_sum", want.out_etx_sum, got.out_etx_sum);
      cmp_field("entry_total", want.entry_total, got.entry_total);
      cmp_field("last_of_report", want.last_of_report, got.last_of_report);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_neighbors(drv_beat);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
          drv_beat = beat_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= drv_beat.func;
          in_ch.sender_addr <= drv_beat.sender_addr;
          in_ch.msg_id <= drv_beat.msg_id;
          in_ch.link_quality <= drv_beat.link_quality;
          in_ch.signal_strength <= drv_beat.signal_strength;
          in_ch.route_metric <= drv_beat.route_metric;
          in_ch.etx_sum <= drv_beat.etx_sum;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats: table extremes, both id orderings, a full table, empty reports.
    write_own_address(16'hFFFF);
    add_report();
    add_rx(16'h0000, 8'h00, 8'h00, 8'h80, 16'h0000, 32'h0000_0000);
    add_rx(16'hFFFF, 8'hFF, 8'hFF, 8'h7F, 16'hFFFF, 32'hFFFF_FFFF);
    add_rx(16'h0000, 8'h05, 8'h12, 8'h01, 16'h0001, 32'h0000_0001);
    add_rx(16'h0000, 8'h06, 8'h34, 8'hFF, 16'h8000, 32'h8000_0000);
    add_rx(16'hFFFF, 8'h00, 8'h56, 8'h02, 16'h1234, 32'h1234_5678);
    add_rx(16'h0000, 8'h06, 8'h78, 8'hFE, 16'h5555, 32'h5555_5555);
    for (int k = 1; k <= 6; k++) begin
      add_rx(16'(k), 8'(k * 10), 8'(k), 8'(k), 16'(k), 32'(k));
    end
    add_rx(16'h1234, 8'h40, 8'hAA, 8'hAA, 16'hAAAA, 32'hAAAA_AAAA);
    add_rx(16'h0006, 8'hF0, 8'h55, 8'h55, 16'h5555, 32'h5555_5555);
    add_report();
    add_report();
    add_rx(16'h8000, 8'h80, 8'h80, 8'h80, 16'h8000, 32'h8000_0000);
    add_report();
    settle();

    // Receiver holds off while the sender keeps offering beats.
    write_own_address(16'($urandom));
    refill_pool();
    hold_left = 400;
    for (int i = 0; i < 12; i++) beat_q.push_back(gen_beat(0));
    add_report();
    for (int i = 0; i < 45; i++) beat_q.push_back(gen_beat(8));
    settle();

    write_own_address(16'h0000);
    refill_pool();
    snd_idle = 14;
    rcv_idle = 79;
    for (int i = 0; i < 130; i++) beat_q.push_back(gen_beat(8));
    settle();

    write_own_address(16'($urandom));
    refill_pool();
    snd_idle = 79;
    rcv_idle = 14;
    for (int i = 0; i < 130; i++) beat_q.push_back(gen_beat(8));
    settle();

    write_own_address(16'($urandom));
    refill_pool();
    snd_idle = 0;
    rcv_idle = 0;
    for (int i = 0; i < 130; i++) beat_q.push_back(gen_beat(8));
    settle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/nlt_pkg.sv
hdl/nlt_in_if.sv
hdl/nlt_out_if.sv
hdl/nlt_seq.sv
hdl/nlt_dp.sv
hdl/neighbor_loss_table_top.sv
tb/neighbor_loss_table_top_tb.sv
